// ===== src/bst_pkg.sv =====
// Shared types and constants for the byte stream tokenizer.
// Used by bst_core, bst_outq and byte_stream_tokenizer; depends on nothing.
package bst_pkg;

    localparam int TEXT_BYTES_DEF    = 16384;
    localparam int KEYWORD_COUNT_DEF = 6;
    localparam int FIELD_W           = 14;
    localparam int TEXT_BYTES        = TEXT_BYTES_DEF;
    localparam int SAT_MAX_INT       = (TEXT_BYTES - 1) < 16383 ? (TEXT_BYTES - 1) : 16383;
    localparam logic [FIELD_W-1:0] SAT_MAX    = FIELD_W'(SAT_MAX_INT);
    localparam logic [FIELD_W-1:0] LIMIT_RST  = 14'd1000;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_WORD   = 2'd1;
    localparam logic [1:0] MODE_STRING = 2'd2;

    localparam logic [1:0] ST_TOKEN = 2'd0;
    localparam logic [1:0] ST_UNTERM = 2'd1;
    localparam logic [1:0] ST_END   = 2'd2;

    localparam logic [2:0] KIND_KEYWORD = 3'd0;
    localparam logic [2:0] KIND_IDENT   = 3'd1;
    localparam logic [2:0] KIND_NUMBER  = 3'd2;
    localparam logic [2:0] KIND_OPER    = 3'd3;
    localparam logic [2:0] KIND_DELIM   = 3'd4;
    localparam logic [2:0] KIND_STRING  = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN = 3'd6;

    typedef struct packed {
        logic [1:0]         status;
        logic [2:0]         kind;
        logic [FIELD_W-1:0] start_offset;
        logic [FIELD_W-1:0] token_length;
        logic [FIELD_W-1:0] line_number;
        logic [FIELD_W-1:0] token_index;
        logic               last_of_run;
    } bst_result_t;

    function automatic logic [FIELD_W-1:0] sat_inc(input logic [FIELD_W-1:0] v);
        return (v < SAT_MAX) ? v + 1'b1 : SAT_MAX;
    endfunction

endpackage

// ===== src/byte_stream_tokenizer.sv =====
// Top level of the byte stream tokenizer: input register, scanner and result queue.
// Depends on bst_pkg, bst_core and bst_outq.
//
// Text bytes enter on the ch channel (valid/ready), one item per byte; a zero byte
// ends the run. Tokens leave on the result channel as status, kind, start_offset,
// token_length, line_number, token_index and last_of_run; every byte that causes
// results marks its final one with last_of_run. A byte causes zero, one or two
// result items, and each run closes with an end-of-text item.
// The token limit is written on the cfg channel (always ready); the user must write it
// only while the block is idle, which the block itself does not enforce; it resets to 1000.
// A byte is held in the input register and scanned once the result queue has room;
// its result items are written into the queue and offered from there. One byte is
// taken every cycle while the result queue has room for two items; bytes that give two
// items are given out one at a time, which the four-entry queue absorbs.
// When the receiver stalls, the queue fills and ready drops; nothing is lost.
// Reset empties the queue and puts the scanner at the start of a run on line 1.
module byte_stream_tokenizer #(
    parameter int KEYWORD_COUNT = bst_pkg::KEYWORD_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bst_pkg::FIELD_W-1:0]  cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   ch,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [2:0]                   kind,
    output logic [bst_pkg::FIELD_W-1:0]  start_offset,
    output logic [bst_pkg::FIELD_W-1:0]  token_length,
    output logic [bst_pkg::FIELD_W-1:0]  line_number,
    output logic [bst_pkg::FIELD_W-1:0]  token_index,
    output logic                         last_of_run
);
    import bst_pkg::*;

    logic [FIELD_W-1:0] limit_reg;
    logic               hold_reg, hold_next;
    logic [7:0]         ch_reg;
    logic               go;
    logic               room;
    logic               accept;
    bst_result_t        res0, res1, head;
    logic [1:0]         res_count;

    assign cfg_ready = 1'b1;
    assign go        = hold_reg && room;
    assign in_ready  = !hold_reg || go;
    assign accept    = in_valid && in_ready;
    assign hold_next = accept ? 1'b1 : (go ? 1'b0 : hold_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RST;
            hold_reg  <= 1'b0;
        end
        else
        begin
            hold_reg <= hold_next;
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg <= ch;
        end
    end

    bst_core #(
        .KEYWORD_COUNT(KEYWORD_COUNT)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .ch         (ch_reg),
        .token_limit(limit_reg),
        .res0       (res0),
        .res1       (res1),
        .res_count  (res_count)
    );

    bst_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_count(res_count),
        .push0     (res0),
        .push1     (res1),
        .pop       (out_valid && out_ready),
        .room      (room),
        .not_empty (out_valid),
        .head      (head)
    );

    assign status       = head.status;
    assign kind         = head.kind;
    assign start_offset = head.start_offset;
    assign token_length = head.token_length;
    assign line_number  = head.line_number;
    assign token_index  = head.token_index;
    assign last_of_run  = head.last_of_run;

endmodule

// ===== src/bst_core.sv =====
// Per-byte scanner: holds the scan state and forms up to two result items per byte.
// Depends on bst_pkg.
module bst_core #(
    parameter int KEYWORD_COUNT = bst_pkg::KEYWORD_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  logic [7:0]                   ch,
    input  logic [bst_pkg::FIELD_W-1:0]  token_limit,
    output bst_pkg::bst_result_t         res0,
    output bst_pkg::bst_result_t         res1,
    output logic [1:0]                   res_count
);
    import bst_pkg::*;

    localparam int KW_CHARS = 10;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_US    = 8'h5F;

    function automatic logic [3:0] kw_len(input logic [3:0] slot);
        case (slot)
            4'd0: return 4'd3;
            4'd1: return 4'd7;
            4'd2: return 4'd5;
            4'd3: return 4'd9;
            4'd4: return 4'd6;
            4'd5: return 4'd5;
            default: return 4'd0;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(input logic [3:0] slot, input logic [3:0] pos);
        logic [8*KW_CHARS-1:0] w;
        case (slot)
            4'd0: w = {"put", 56'd0};
            4'd1: w = {"display", 24'd0};
            4'd2: w = {"check", 40'd0};
            4'd3: w = {"otherwise", 8'd0};
            4'd4: w = {"repeat", 32'd0};
            4'd5: w = {"range", 40'd0};
            default: w = '0;
        endcase
        return w[8*(KW_CHARS-1-int'(pos)) +: 8];
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" ||
               c == "=" || c == ">";
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return c == "<" || c == "(" || c == ")" || c == "{" || c == "}" || c == ";";
    endfunction

    logic [1:0]               mode_reg, mode_next;
    logic [FIELD_W-1:0]       line_reg, line_next;
    logic [FIELD_W-1:0]       offset_reg, offset_next;
    logic [FIELD_W-1:0]       count_reg, count_next;
    logic [FIELD_W-1:0]       wstart_reg, wstart_next;
    logic [FIELD_W-1:0]       wlen_reg, wlen_next;
    logic [KEYWORD_COUNT-1:0] alive_reg, alive_next;
    logic                     ident_reg, ident_next;
    logic                     digits_reg, digits_next;

    logic                     term;
    logic                     new_word;
    logic [KEYWORD_COUNT-1:0] base_alive, wb_alive, kw_end;
    logic [FIELD_W-1:0]       base_len;
    logic                     base_ident, wb_ident, wb_digits;
    logic [3:0]               pos;
    logic [2:0]               word_kind;

    // Keyword and type flags for a byte in a word, and the kind of the open word.
    always_comb
    begin
        term       = is_space(ch) || is_oper(ch) || is_delim(ch);
        new_word   = (mode_reg != MODE_WORD) || term;
        base_alive = new_word ? '1 : alive_reg;
        base_len   = new_word ? '0 : wlen_reg;
        base_ident = new_word ? 1'b1 : ident_reg;
        pos        = (base_len < FIELD_W'(KW_CHARS)) ? base_len[3:0] : 4'd0;
        for (int i = 0; i < KEYWORD_COUNT; i++)
        begin
            wb_alive[i] = base_alive[i] && (base_len < {10'd0, kw_len(4'(i))}) &&
                          (kw_char(4'(i), pos) == ch);
            kw_end[i]   = alive_reg[i] && (wlen_reg == {10'd0, kw_len(4'(i))});
        end
        if (base_len == '0)
        begin
            wb_ident = is_alpha(ch) || ch == CH_US;
        end
        else
        begin
            wb_ident = base_ident && (is_alpha(ch) || is_digit(ch) || ch == CH_US);
        end
        wb_digits = (new_word ? 1'b1 : digits_reg) && is_digit(ch);

        if (|kw_end)
        begin
            word_kind = KIND_KEYWORD;
        end
        else if (ident_reg)
        begin
            word_kind = KIND_IDENT;
        end
        else if (digits_reg)
        begin
            word_kind = KIND_NUMBER;
        end
        else
        begin
            word_kind = KIND_UNKNOWN;
        end
    end

    bst_result_t res [2];
    logic [1:0]  n;
    logic        handled;
    logic [FIELD_W-1:0] cnt_after;

    always_comb
    begin
        mode_next   = mode_reg;
        line_next   = line_reg;
        offset_next = offset_reg;
        count_next  = count_reg;
        wstart_next = wstart_reg;
        wlen_next   = wlen_reg;
        alive_next  = alive_reg;
        ident_next  = ident_reg;
        digits_next = digits_reg;
        handled     = 1'b0;
        cnt_after   = count_reg;
        n           = 2'd0;
        for (int k = 0; k < 2; k++)
        begin
            res[k].status       = ST_TOKEN;
            res[k].kind         = KIND_KEYWORD;
            res[k].start_offset = '0;
            res[k].token_length = '0;
            res[k].line_number  = line_reg;
            res[k].token_index  = '0;
            res[k].last_of_run  = 1'b0;
        end

        if (ch == CH_NUL)
        begin
            if (mode_reg == MODE_WORD)
            begin
                res[0].kind         = word_kind;
                res[0].start_offset = wstart_reg;
                res[0].token_length = wlen_reg;
                res[0].token_index  = count_reg;
                cnt_after           = sat_inc(count_reg);
                n                   = 2'd1;
            end
            else if (mode_reg == MODE_STRING)
            begin
                res[0].status       = ST_UNTERM;
                res[0].kind         = KIND_STRING;
                res[0].start_offset = wstart_reg;
                res[0].token_length = wlen_reg;
                res[0].token_index  = count_reg;
                n                   = 2'd1;
            end
            res[n[0]].status       = ST_END;
            res[n[0]].kind         = KIND_KEYWORD;
            res[n[0]].start_offset = offset_reg;
            res[n[0]].token_length = '0;
            res[n[0]].token_index  = cnt_after;
            n           = n + 2'd1;
            mode_next   = MODE_IDLE;
            line_next   = 14'd1;
            offset_next = '0;
            count_next  = '0;
        end
        else
        begin
            if (mode_reg == MODE_STRING)
            begin
                if (ch == CH_QUOTE)
                begin
                    res[0].kind         = KIND_STRING;
                    res[0].start_offset = wstart_reg;
                    res[0].token_length = wlen_reg;
                    res[0].token_index  = count_reg;
                    cnt_after           = sat_inc(count_reg);
                    n                   = 2'd1;
                    mode_next           = MODE_IDLE;
                end
                else
                begin
                    wlen_next = sat_inc(wlen_reg);
                end
            end
            else
            begin
                if (mode_reg == MODE_WORD)
                begin
                    if (term)
                    begin
                        res[0].kind         = word_kind;
                        res[0].start_offset = wstart_reg;
                        res[0].token_length = wlen_reg;
                        res[0].token_index  = count_reg;
                        cnt_after           = sat_inc(count_reg);
                        n                   = 2'd1;
                        mode_next           = MODE_IDLE;
                    end
                    else
                    begin
                        alive_next  = wb_alive;
                        ident_next  = wb_ident;
                        digits_next = wb_digits;
                        wlen_next   = sat_inc(wlen_reg);
                        handled     = 1'b1;
                    end
                end
                if (!handled && cnt_after < token_limit)
                begin
                    if (ch == CH_NL)
                    begin
                        line_next = sat_inc(line_reg);
                    end
                    else if (is_space(ch))
                    begin
                        line_next = line_reg;
                    end
                    else if (ch == CH_QUOTE)
                    begin
                        mode_next   = MODE_STRING;
                        wstart_next = sat_inc(offset_reg);
                        wlen_next   = '0;
                    end
                    else if (is_oper(ch) || is_delim(ch))
                    begin
                        res[n[0]].kind         = is_oper(ch) ? KIND_OPER : KIND_DELIM;
                        res[n[0]].start_offset = offset_reg;
                        res[n[0]].token_length = 14'd1;
                        res[n[0]].token_index  = cnt_after;
                        cnt_after              = sat_inc(cnt_after);
                        n                      = n + 2'd1;
                    end
                    else
                    begin
                        mode_next   = MODE_WORD;
                        wstart_next = offset_reg;
                        alive_next  = wb_alive;
                        ident_next  = wb_ident;
                        digits_next = wb_digits;
                        wlen_next   = 14'd1;
                    end
                end
            end
            count_next  = cnt_after;
            offset_next = sat_inc(offset_reg);
        end

        if (n == 2'd1)
        begin
            res[0].last_of_run = 1'b1;
        end
        else if (n == 2'd2)
        begin
            res[1].last_of_run = 1'b1;
        end
    end

    assign res0      = res[0];
    assign res1      = res[1];
    assign res_count = go ? n : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            line_reg   <= 14'd1;
            offset_reg <= '0;
            count_reg  <= '0;
            wstart_reg <= '0;
            wlen_reg   <= '0;
            alive_reg  <= '1;
            ident_reg  <= 1'b1;
            digits_reg <= 1'b1;
        end
        else if (go)
        begin
            mode_reg   <= mode_next;
            line_reg   <= line_next;
            offset_reg <= offset_next;
            count_reg  <= count_next;
            wstart_reg <= wstart_next;
            wlen_reg   <= wlen_next;
            alive_reg  <= alive_next;
            ident_reg  <= ident_next;
            digits_reg <= digits_next;
        end
    end

endmodule

// ===== src/bst_outq.sv =====
// Four-entry result queue: takes up to two result items a cycle, gives out one.
// Depends on bst_pkg.
module bst_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           push_count,
    input  bst_pkg::bst_result_t push0,
    input  bst_pkg::bst_result_t push1,
    input  logic                 pop,
    output logic                 room,
    output logic                 not_empty,
    output bst_pkg::bst_result_t head
);
    import bst_pkg::*;

    bst_result_t entry_reg [4];
    logic [1:0]  wr_reg, wr_next;
    logic [1:0]  rd_reg, rd_next;
    logic [2:0]  fill_reg, fill_next;

    assign room      = fill_reg <= 3'd2;
    assign not_empty = fill_reg != 3'd0;
    assign head      = entry_reg[rd_reg];

    always_comb
    begin
        wr_next   = wr_reg + push_count;
        rd_next   = rd_reg + {1'b0, pop};
        fill_next = fill_reg + {1'b0, push_count} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[wr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            entry_reg[wr_reg + 2'd1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

endmodule
